### hdl/ara_pkg.sv
// Shared constants, codes and types of the atlas rectangle allocator.
// Used by the divider, the free-rectangle cell and the top level; depends on nothing.
`default_nettype none
package ara_pkg;

    localparam int FREE_SLOTS     = 64;
    localparam int IMAGE_SLOTS    = 64;
    localparam int MAX_PAGE_COUNT = 16;

    localparam int FIDX_W  = $clog2(FREE_SLOTS);
    localparam int FCNT_W  = $clog2(FREE_SLOTS + 1);
    localparam int IIDX_W  = $clog2(IMAGE_SLOTS);
    localparam int PAGES_W = $clog2(MAX_PAGE_COUNT + 1);

    localparam int CFG_W     = 9;
    localparam int MAXP_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CELL_W    = 9;
    localparam int POS_W     = 8;
    localparam int PG_W      = 4;
    localparam int AREA_W    = 17;
    localparam int AGE_W     = 16;
    localparam int ID_W      = 16;
    localparam int PX_W      = 14;
    localparam int AW_W      = 15;
    localparam int OUT_PX_W  = 16;
    localparam int PROD_W    = 2 * CELL_W;

    localparam int DIV_NUM_W = 15;
    localparam int DIV_DEN_W = 9;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 88;

    localparam logic [1:0] MODE_REQUEST = 2'd0;
    localparam logic [1:0] MODE_REMOVE  = 2'd1;
    localparam logic [1:0] MODE_QUERY   = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE  = 3'd1;
    localparam logic [2:0] ST_NO_SPACE   = 3'd2;
    localparam logic [2:0] ST_UNKNOWN_ID = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_W    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_H    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAGES = 3'd4;

    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [CELL_W-1:0] w;
        logic [CELL_W-1:0] h;
        logic [PG_W-1:0]   pg;
    } t_rect;

    // Best-fit candidate travelling down the cell chain.
    typedef struct packed {
        logic              tv;
        logic              found;
        logic [AREA_W-1:0] area;
        logic [AGE_W-1:0]  age;
        t_rect             rect;
        logic [FIDX_W-1:0] idx;
    } t_tok;

    // Write command broadcast to every cell.
    typedef struct packed {
        logic              init;
        logic              add;
        logic              clr;
        logic [FIDX_W-1:0] idx;
        t_rect             rect;
        logic [AREA_W-1:0] area;
        logic [AGE_W-1:0]  age;
    } t_wr;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] cx;
        logic [POS_W-1:0] cy;
        logic [PG_W-1:0]  pg;
        logic [PX_W-1:0]  wpx;
        logic [PX_W-1:0]  hpx;
        logic             mip;
    } t_img;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DIVW, S_DIVH, S_LAUNCH, S_SCAN, S_DECIDE,
        S_SPLIT_A, S_SPLIT_B, S_COMMIT, S_FIND_RD, S_FIND_CMP,
        S_REM_DIVW, S_REM_DIVH, S_REM_ADD, S_OUT
    } t_state;

endpackage
`default_nettype wire

### hdl/ara_div.sv
// Restoring divider, one quotient bit per cycle, for rounding sizes to cells.
// Depends on ara_pkg.
`default_nettype none
module ara_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [ara_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic [ara_pkg::DIV_DEN_W-1:0] i_den,
    output logic                               o_done,
    output logic [ara_pkg::DIV_NUM_W-1:0]      o_quot
);
    import ara_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W:0]   shifted;
    logic                 ge;
    logic [DIV_DEN_W:0]   diff;

    always_comb begin
        shifted = {r_rem, r_num[DIV_NUM_W-1]};
        ge      = shifted >= {1'b0, r_den};
        diff    = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The quotient bits shift into the numerator register as it empties.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            r_num <= {r_num[DIV_NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule
`default_nettype wire

### hdl/ara_free_cell.sv
// One free-rectangle slot plus one stage of the best-fit search chain.
// Depends on ara_pkg.
`default_nettype none
module ara_free_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [ara_pkg::FIDX_W-1:0] i_index,
    input  wire logic [ara_pkg::CELL_W-1:0] i_nw,
    input  wire logic [ara_pkg::CELL_W-1:0] i_nh,
    input  wire ara_pkg::t_wr               i_wr,
    input  wire ara_pkg::t_tok              i_tok,
    output ara_pkg::t_tok                   o_tok,
    output logic                            o_valid
);
    import ara_pkg::*;

    logic              r_valid;
    t_rect             r_rect;
    logic [AREA_W-1:0] r_area;
    logic [AGE_W-1:0]  r_age;
    logic              r_tv;
    t_tok              r_tok;
    logic              fits;
    logic              take;
    t_tok              n_tok;
    logic              hit;

    assign hit = (i_wr.idx == i_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tv    <= 1'b0;
        end else begin
            r_tv <= i_tok.tv;
            if (i_wr.init) begin
                r_valid <= (i_index == '0);
            end else if (i_wr.add && hit) begin
                r_valid <= 1'b1;
            end else if (i_wr.clr && hit) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.init || (i_wr.add && hit)) begin
            r_rect <= i_wr.rect;
            r_area <= i_wr.area;
            r_age  <= i_wr.age;
        end
        r_tok <= n_tok;
    end

    // Strict compare keeps the lower slot on equal area and age.
    always_comb begin
        fits = r_valid && (r_rect.w >= i_nw) && (r_rect.h >= i_nh);
        take = fits && (!i_tok.found || (r_area < i_tok.area) ||
                        ((r_area == i_tok.area) && (r_age < i_tok.age)));
        n_tok = i_tok;
        if (take) begin
            n_tok.found = 1'b1;
            n_tok.area  = r_area;
            n_tok.age   = r_age;
            n_tok.rect  = r_rect;
            n_tok.idx   = i_index;
        end
    end

    always_comb begin
        o_tok    = r_tok;
        o_tok.tv = r_tv;
    end

    assign o_valid = r_valid;

endmodule
`default_nettype wire

### hdl/atlas_rectangle_allocator.sv
// Top level of the atlas rectangle allocator: sequencer, image table and cell chain.
// Depends on ara_pkg, ara_div and ara_free_cell.
`default_nettype none
// The allocator takes one request at a time on the slave stream and answers each with
// exactly one result on the master stream. A placement request rounds the image size
// up to whole grid cells with a serial divider, one dimension after the other, then
// sends a search token down a chain of FREE_SLOTS cells, one cell per cycle, which
// picks the fitting free rectangle of smallest area, oldest first. When nothing fits,
// a new page is opened, if allowed, and the search runs once more. Remove and query
// walk the image table slot by slot until the id is found, and remove adds two divider
// runs; an unknown id is reported once every slot has been read.
// Writing any geometry register resets the allocator on the following cycle, during
// which no request is taken; the same one-cycle clear follows reset. Configuration
// writes are always accepted and should only be made while the block is idle.
module atlas_rectangle_allocator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ara_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ara_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // width_px[13:0], height_px[27:14], has_mipmap[28], image_id[44:29], zero pad
    input  wire logic [ara_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // mode[1:0]
    input  wire logic [1:0]                    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // image_id_res[15:0], x_px[31:16], y_px[47:32], page[51:48],
    // width_out_px[65:52], height_out_px[79:66], mipmap_out[80], zero pad
    output logic [ara_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // status[2:0]
    output logic [2:0]                         m_axis_tuser
);
    import ara_pkg::*;

    // Configuration registers and their effective values (zero acts as one).
    logic [CFG_W-1:0]  r_cw, r_ch, r_gc, r_gr;
    logic [MAXP_W-1:0] r_mp;
    logic [CFG_W-1:0]  cwe, che, gce, gre;
    logic [PAGES_W-1:0] maxp;
    logic [PROD_W-1:0] r_lim_w, r_lim_h;
    logic              r_init;

    // Sequencer state.
    t_state             r_state, n_state;
    logic [1:0]         r_mode, n_mode;
    logic [PX_W-1:0]    r_w, n_w, r_h, n_h;
    logic               r_mip, n_mip;
    logic [ID_W-1:0]    r_id, n_id;
    logic [AW_W-1:0]    r_aw, n_aw;
    logic [CELL_W-1:0]  r_nw, n_nw, r_nh, n_nh;
    logic [IIDX_W-1:0]  r_is, n_is, r_k, n_k;
    logic               r_second, n_second;
    t_tok               r_best, n_best;
    logic [AGE_W-1:0]   r_ins, n_ins;
    logic [ID_W-1:0]    r_next_id, n_next_id;
    logic [PAGES_W-1:0] r_pages, n_pages;
    logic [IMAGE_SLOTS-1:0] r_img_valid, n_img_valid;
    t_img               r_ent, n_ent;
    logic [2:0]         r_status, n_status;
    logic               r_ok, n_ok;

    // Result register.
    logic                 r_mv, n_mv;
    logic [M_TDATA_W-1:0] r_mdata, n_mdata;
    logic [2:0]           r_muser, n_muser;

    // Image table memory.
    t_img r_img_mem [IMAGE_SLOTS];
    t_img r_img_rd;
    logic              img_we;
    t_img              img_wdata;

    // Divider and cell chain hookup.
    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_quot;
    logic [DIV_DEN_W-1:0] div_den;
    t_wr                  wr;
    logic [PROD_W-1:0]    wr_prod;
    t_tok                 tok [FREE_SLOTS+1];
    logic [FREE_SLOTS-1:0] fvalid;
    logic                 scan_start;

    logic              ff_found, img_found;
    logic [FIDX_W-1:0] ff_idx;
    logic [IIDX_W-1:0] img_idx;
    logic [FCNT_W-1:0] free_cnt;
    logic [1:0]        pieces;
    logic [AW_W-1:0]   ent_aw;
    logic [PROD_W-1:0] x_prod, y_prod;

    function automatic logic [CELL_W-1:0] fix_q(input logic [DIV_NUM_W-1:0] q);
        return (q == '0) ? CELL_W'(1) : q[CELL_W-1:0];
    endfunction

    always_comb begin
        cwe = (r_cw == '0) ? CFG_W'(1) : r_cw;
        che = (r_ch == '0) ? CFG_W'(1) : r_ch;
        gce = (r_gc == '0) ? CFG_W'(1) : r_gc;
        gre = (r_gr == '0) ? CFG_W'(1) : r_gr;
        if (r_mp == '0) begin
            maxp = PAGES_W'(1);
        end else if (32'(r_mp) > MAX_PAGE_COUNT) begin
            maxp = PAGES_W'(MAX_PAGE_COUNT);
        end else begin
            maxp = PAGES_W'(r_mp);
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw   <= CFG_W'(16);
            r_ch   <= CFG_W'(16);
            r_gc   <= CFG_W'(64);
            r_gr   <= CFG_W'(64);
            r_mp   <= MAXP_W'(1);
            r_init <= 1'b1;
        end else begin
            r_init <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CELL_W:    r_cw <= i_cfg_data;
                    CFG_CELL_H:    r_ch <= i_cfg_data;
                    CFG_GRID_COLS: r_gc <= i_cfg_data;
                    CFG_GRID_ROWS: r_gr <= i_cfg_data;
                    CFG_MAX_PAGES: r_mp <= i_cfg_data[MAXP_W-1:0];
                    default: ;
                endcase
                // A geometry write starts the allocator over once the new value is in.
                if (i_cfg_index < CFG_MAX_PAGES) begin
                    r_init <= 1'b1;
                end
            end
        end
    end

    // Page limits in pixels, kept registered off the configuration.
    always_ff @(posedge i_clk) begin
        r_lim_w <= PROD_W'(gce) * PROD_W'(cwe);
        r_lim_h <= PROD_W'(gre) * PROD_W'(che);
    end

    // Lowest free slot in both tables and the count of free rectangle slots.
    always_comb begin
        ff_found  = 1'b0;
        ff_idx    = '0;
        img_found = 1'b0;
        img_idx   = '0;
        for (int i = FREE_SLOTS - 1; i >= 0; i--) begin
            if (!fvalid[i]) begin
                ff_found = 1'b1;
                ff_idx   = FIDX_W'(i);
            end
        end
        for (int j = IMAGE_SLOTS - 1; j >= 0; j--) begin
            if (!r_img_valid[j]) begin
                img_found = 1'b1;
                img_idx   = IIDX_W'(j);
            end
        end
        free_cnt = FCNT_W'($countones(~fvalid));
    end

    assign pieces = {1'b0, r_best.rect.w != r_nw} + {1'b0, r_best.rect.h != r_nh};
    assign ent_aw = r_img_rd.mip ? (AW_W'(r_img_rd.wpx) + AW_W'(r_img_rd.wpx >> 1))
                                 : AW_W'(r_img_rd.wpx);
    assign x_prod = PROD_W'(r_ent.cx) * PROD_W'(cwe);
    assign y_prod = PROD_W'(r_ent.cy) * PROD_W'(che);

    assign s_axis_tready = (r_state == S_IDLE) && !r_init;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_w         = r_w;
        n_h         = r_h;
        n_mip       = r_mip;
        n_id        = r_id;
        n_aw        = r_aw;
        n_nw        = r_nw;
        n_nh        = r_nh;
        n_is        = r_is;
        n_k         = r_k;
        n_second    = r_second;
        n_best      = r_best;
        n_ins       = r_ins;
        n_next_id   = r_next_id;
        n_pages     = r_pages;
        n_img_valid = r_img_valid;
        n_ent       = r_ent;
        n_status    = r_status;
        n_ok        = r_ok;
        n_mv        = r_mv && !m_axis_tready;
        n_mdata     = r_mdata;
        n_muser     = r_muser;
        wr          = '0;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;
        scan_start  = 1'b0;
        img_we      = 1'b0;
        img_wdata   = r_ent;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_mode  = s_axis_tuser;
                    n_w     = s_axis_tdata[13:0];
                    n_h     = s_axis_tdata[27:14];
                    n_mip   = s_axis_tdata[28];
                    n_id    = s_axis_tdata[44:29];
                    n_aw    = s_axis_tdata[28]
                            ? (AW_W'(s_axis_tdata[13:0]) + AW_W'(s_axis_tdata[13:1]))
                            : AW_W'(s_axis_tdata[13:0]);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_ok = 1'b0;
                case (r_mode)
                    MODE_REQUEST: begin
                        if ((PROD_W'(r_aw) > r_lim_w) || (PROD_W'(r_h) > r_lim_h)) begin
                            n_status = ST_TOO_LARGE;
                            n_state  = S_OUT;
                        end else if (!img_found) begin
                            n_status = ST_TABLE_FULL;
                            n_state  = S_OUT;
                        end else begin
                            n_is      = img_idx;
                            div_start = 1'b1;
                            div_num   = r_aw + AW_W'(cwe) - AW_W'(1);
                            div_den   = cwe;
                            n_state   = S_DIVW;
                        end
                    end
                    MODE_REMOVE, MODE_QUERY: begin
                        n_k     = '0;
                        n_state = S_FIND_RD;
                    end
                    default: begin
                        n_status = ST_UNKNOWN_ID;
                        n_state  = S_OUT;
                    end
                endcase
            end
            S_DIVW: begin
                if (div_done) begin
                    n_nw      = fix_q(div_quot);
                    div_start = 1'b1;
                    div_num   = AW_W'(r_h) + AW_W'(che) - AW_W'(1);
                    div_den   = che;
                    n_state   = S_DIVH;
                end
            end
            S_DIVH: begin
                if (div_done) begin
                    n_nh     = fix_q(div_quot);
                    n_second = 1'b0;
                    n_state  = S_LAUNCH;
                end
            end
            S_LAUNCH: begin
                scan_start = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                if (tok[FREE_SLOTS].tv) begin
                    n_best  = tok[FREE_SLOTS];
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!r_best.found) begin
                    if (r_second || (r_pages >= maxp)) begin
                        n_status = ST_NO_SPACE;
                        n_state  = S_OUT;
                    end else if (!ff_found) begin
                        n_status = ST_TABLE_FULL;
                        n_state  = S_OUT;
                    end else begin
                        // Open a fresh page as one full-grid rectangle and search again.
                        wr.add     = 1'b1;
                        wr.idx     = ff_idx;
                        wr.rect.x  = '0;
                        wr.rect.y  = '0;
                        wr.rect.w  = gce;
                        wr.rect.h  = gre;
                        wr.rect.pg = r_pages[PG_W-1:0];
                        wr.age     = r_ins;
                        n_ins      = r_ins + 1'b1;
                        n_pages    = r_pages + 1'b1;
                        n_second   = 1'b1;
                        n_state    = S_LAUNCH;
                    end
                end else if (FCNT_W'(pieces) > free_cnt + FCNT_W'(1)) begin
                    n_status = ST_TABLE_FULL;
                    n_state  = S_OUT;
                end else begin
                    wr.clr  = 1'b1;
                    wr.idx  = r_best.idx;
                    n_state = S_SPLIT_A;
                end
            end
            S_SPLIT_A: begin
                if (r_best.rect.w != r_nw) begin
                    wr.add     = 1'b1;
                    wr.idx     = ff_idx;
                    wr.rect.x  = r_best.rect.x + r_nw[POS_W-1:0];
                    wr.rect.y  = r_best.rect.y;
                    wr.rect.w  = r_best.rect.w - r_nw;
                    wr.rect.h  = r_nh;
                    wr.rect.pg = r_best.rect.pg;
                    wr.age     = r_ins;
                    n_ins      = r_ins + 1'b1;
                end
                n_state = S_SPLIT_B;
            end
            S_SPLIT_B: begin
                if (r_best.rect.h != r_nh) begin
                    wr.add     = 1'b1;
                    wr.idx     = ff_idx;
                    wr.rect.x  = r_best.rect.x;
                    wr.rect.y  = r_best.rect.y + r_nh[POS_W-1:0];
                    wr.rect.w  = r_best.rect.w;
                    wr.rect.h  = r_best.rect.h - r_nh;
                    wr.rect.pg = r_best.rect.pg;
                    wr.age     = r_ins;
                    n_ins      = r_ins + 1'b1;
                end
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                img_wdata.id  = r_next_id;
                img_wdata.cx  = r_best.rect.x;
                img_wdata.cy  = r_best.rect.y;
                img_wdata.pg  = r_best.rect.pg;
                img_wdata.wpx = r_w;
                img_wdata.hpx = r_h;
                img_wdata.mip = r_mip;
                img_we        = 1'b1;
                n_ent         = img_wdata;
                n_img_valid[r_is] = 1'b1;
                // Ids skip zero when the counter wraps.
                n_next_id = (r_next_id == '1) ? ID_W'(1) : r_next_id + 1'b1;
                n_status  = ST_OK;
                n_ok      = 1'b1;
                n_state   = S_OUT;
            end
            S_FIND_RD: begin
                n_state = S_FIND_CMP;
            end
            S_FIND_CMP: begin
                if (r_img_valid[r_k] && (r_img_rd.id == r_id)) begin
                    n_ent = r_img_rd;
                    n_is  = r_k;
                    if (r_mode == MODE_QUERY) begin
                        n_status = ST_OK;
                        n_ok     = 1'b1;
                        n_state  = S_OUT;
                    end else if (!ff_found) begin
                        n_status = ST_TABLE_FULL;
                        n_state  = S_OUT;
                    end else begin
                        div_start = 1'b1;
                        div_num   = ent_aw + AW_W'(cwe) - AW_W'(1);
                        div_den   = cwe;
                        n_state   = S_REM_DIVW;
                    end
                end else if (r_k == IIDX_W'(IMAGE_SLOTS - 1)) begin
                    n_status = ST_UNKNOWN_ID;
                    n_state  = S_OUT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_FIND_RD;
                end
            end
            S_REM_DIVW: begin
                if (div_done) begin
                    n_nw      = fix_q(div_quot);
                    div_start = 1'b1;
                    div_num   = AW_W'(r_ent.hpx) + AW_W'(che) - AW_W'(1);
                    div_den   = che;
                    n_state   = S_REM_DIVH;
                end
            end
            S_REM_DIVH: begin
                if (div_done) begin
                    n_nh    = fix_q(div_quot);
                    n_state = S_REM_ADD;
                end
            end
            S_REM_ADD: begin
                // The removed cells come back as one rectangle, never merged.
                wr.add     = 1'b1;
                wr.idx     = ff_idx;
                wr.rect.x  = r_ent.cx;
                wr.rect.y  = r_ent.cy;
                wr.rect.w  = r_nw;
                wr.rect.h  = r_nh;
                wr.rect.pg = r_ent.pg;
                wr.age     = r_ins;
                n_ins      = r_ins + 1'b1;
                n_img_valid[r_is] = 1'b0;
                n_status   = ST_OK;
                n_ok       = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!r_mv || m_axis_tready) begin
                    n_mv    = 1'b1;
                    n_muser = r_status;
                    n_mdata = '0;
                    if (r_ok) begin
                        n_mdata[15:0]  = r_ent.id;
                        n_mdata[31:16] = x_prod[OUT_PX_W-1:0];
                        n_mdata[47:32] = y_prod[OUT_PX_W-1:0];
                        n_mdata[51:48] = r_ent.pg;
                        n_mdata[65:52] = r_ent.wpx;
                        n_mdata[79:66] = r_ent.hpx;
                        n_mdata[80]    = r_ent.mip;
                    end else if (r_mode != MODE_REQUEST) begin
                        n_mdata[15:0] = r_id;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Clearing after reset or a geometry write: one full-grid rectangle on page 0.
        if (r_init) begin
            wr          = '0;
            wr.init     = 1'b1;
            wr.rect.w   = gce;
            wr.rect.h   = gre;
            n_img_valid = '0;
            n_ins       = AGE_W'(1);
            n_next_id   = ID_W'(1);
            n_pages     = PAGES_W'(1);
        end

        wr_prod = PROD_W'(wr.rect.w) * PROD_W'(wr.rect.h);
        wr.area = wr_prod[AREA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_img_valid <= '0;
            r_ins       <= AGE_W'(1);
            r_next_id   <= ID_W'(1);
            r_pages     <= PAGES_W'(1);
            r_mv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_img_valid <= n_img_valid;
            r_ins       <= n_ins;
            r_next_id   <= n_next_id;
            r_pages     <= n_pages;
            r_mv        <= n_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_w      <= n_w;
        r_h      <= n_h;
        r_mip    <= n_mip;
        r_id     <= n_id;
        r_aw     <= n_aw;
        r_nw     <= n_nw;
        r_nh     <= n_nh;
        r_is     <= n_is;
        r_k      <= n_k;
        r_second <= n_second;
        r_best   <= n_best;
        r_ent    <= n_ent;
        r_status <= n_status;
        r_ok     <= n_ok;
        r_mdata  <= n_mdata;
        r_muser  <= n_muser;
    end

    always_ff @(posedge i_clk) begin
        if (img_we) begin
            r_img_mem[r_is] <= img_wdata;
        end
        r_img_rd <= r_img_mem[r_k];
    end

    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;

    ara_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // The search token enters the first cell and passes the register of every cell before it leaves the last one.
    always_comb begin
        tok[0]    = '0;
        tok[0].tv = scan_start;
    end

    for (genvar g = 0; g < FREE_SLOTS; g++) begin : g_cell
        ara_free_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (FIDX_W'(g)),
            .i_nw    (r_nw),
            .i_nh    (r_nh),
            .i_wr    (wr),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .o_valid (fvalid[g])
        );
    end

`ifndef SYNTHESIS
    a_pages_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pages) <= MAX_PAGE_COUNT)
        else $error("open page count above the limit");

    a_scan_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[FREE_SLOTS].tv |-> (r_state == S_SCAN))
        else $error("search token finished outside the scan wait");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIVW || r_state == S_DIVH ||
                      r_state == S_REM_DIVW || r_state == S_REM_DIVH))
        else $error("divider finished with nobody waiting");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_CHECK))
        else $error("accepted request did not start");
`endif

endmodule
`default_nettype wire
